@@ sv/afr_pkg.sv @@
package afr_pkg;

    localparam int PAYLOAD_DEPTH = 32;
    localparam int ADDR_W        = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int COUNT_W       = $clog2(PAYLOAD_DEPTH + 1);
    localparam int LEN_MAX       = 63;

    localparam logic [7:0] CH_SOH  = 8'h01;
    localparam logic [7:0] CH_STX  = 8'h02;
    localparam logic [7:0] CH_ETX  = 8'h03;
    localparam logic [7:0] CH_EOT  = 8'h04;
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_FLIP = 8'h20;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_ACK  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        MODE_IDLE         = 3'd0,
        MODE_ADDR         = 3'd1,
        MODE_PAYLOAD      = 3'd2,
        MODE_SKIP_PAYLOAD = 3'd3,
        MODE_SKIP_REPLY   = 3'd4
    } t_mode;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    typedef struct packed {
        logic       ready;
        logic [5:0] length;
        logic [7:0] rd;
        logic       ovf;
    } t_result;

endpackage

@@ sv/afr_store.sv @@
module afr_store (
    input  logic                       i_clk,
    input  afr_pkg::t_wr               i_wr,
    input  logic                       i_rd_en,
    input  logic [afr_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [7:0]                 o_q
);
    import afr_pkg::*;

    logic [7:0] r_mem [PAYLOAD_DEPTH];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_q = r_q;

endmodule

@@ sv/afr_ctrl.sv @@
module afr_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [7:0]                 i_cfg_data,
    input  logic                       i_fire,
    input  logic [1:0]                 i_opcode,
    input  logic [7:0]                 i_rx_byte,
    input  logic [4:0]                 i_read_index,
    output afr_pkg::t_wr               o_wr,
    output logic [afr_pkg::ADDR_W-1:0] o_rd_addr,
    output logic                       o_hit,
    output afr_pkg::t_result           o_result
);
    import afr_pkg::*;

    t_mode              r_mode, n_mode;
    logic               r_esc, n_esc;
    logic               r_pend, n_pend;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [7:0]         r_node_addr;

    t_opcode    op;
    logic       is_ctl;
    logic       full;
    logic [7:0] data_byte;

    assign op        = t_opcode'(i_opcode);
    assign is_ctl    = (i_rx_byte == CH_SOH) || (i_rx_byte == CH_EOT) ||
                       (i_rx_byte == CH_STX) || (i_rx_byte == CH_ETX) ||
                       (i_rx_byte == CH_ESC);
    assign full      = 32'(r_count) >= PAYLOAD_DEPTH;
    assign data_byte = r_esc ? (i_rx_byte ^ CH_FLIP) : i_rx_byte;

    // next state
    always_comb begin
        n_mode  = r_mode;
        n_esc   = r_esc;
        n_pend  = r_pend;
        n_count = r_count;
        case (op)
            OP_BYTE: begin
                case (i_rx_byte)
                    CH_SOH: begin
                        n_mode = MODE_ADDR;
                        n_esc  = 1'b0;
                    end
                    CH_EOT: begin
                        if (r_mode == MODE_PAYLOAD) begin
                            n_pend = 1'b1;
                        end
                        n_mode = MODE_IDLE;
                        n_esc  = 1'b0;
                    end
                    CH_STX: begin
                        n_mode = MODE_SKIP_REPLY;
                        n_esc  = 1'b0;
                    end
                    CH_ETX: begin
                        n_mode = MODE_IDLE;
                        n_esc  = 1'b0;
                    end
                    CH_ESC: begin
                        n_esc = 1'b1;
                    end
                    default: begin
                        n_esc = 1'b0;
                        case (r_mode)
                            MODE_SKIP_PAYLOAD, MODE_SKIP_REPLY: begin
                                n_mode = r_mode;
                            end
                            MODE_ADDR: begin
                                if (data_byte == r_node_addr && !r_pend) begin
                                    n_mode  = MODE_PAYLOAD;
                                    n_count = '0;
                                end else begin
                                    n_mode = MODE_SKIP_PAYLOAD;
                                end
                            end
                            MODE_PAYLOAD: begin
                                if (full) begin
                                    n_mode = MODE_IDLE;
                                end else begin
                                    n_count = r_count + COUNT_W'(1);
                                end
                            end
                            default: begin
                                n_mode = MODE_IDLE;
                            end
                        endcase
                    end
                endcase
            end
            OP_ACK: begin
                if (r_pend) begin
                    n_pend  = 1'b0;
                    n_count = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // outputs; the stored byte joins the result once the store's registered read returns
    always_comb begin
        o_wr.en   = i_fire && op == OP_BYTE && !is_ctl && r_mode == MODE_PAYLOAD && !full;
        o_wr.addr = ADDR_W'(r_count);
        o_wr.data = data_byte;
        o_rd_addr = ADDR_W'(i_read_index);
        o_hit     = op == OP_READ && 32'(i_read_index) < 32'(r_count) &&
                    32'(i_read_index) < PAYLOAD_DEPTH;

        o_result.ready  = n_pend;
        o_result.length = (32'(n_count) > LEN_MAX) ? 6'(LEN_MAX) : 6'(n_count);
        o_result.rd     = 8'h00;
        o_result.ovf    = op == OP_BYTE && !is_ctl && r_mode == MODE_PAYLOAD && full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_esc       <= 1'b0;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_node_addr <= 8'h00;
        end else begin
            if (i_fire) begin
                r_mode  <= n_mode;
                r_esc   <= n_esc;
                r_pend  <= n_pend;
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_node_addr <= i_cfg_data;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= PAYLOAD_DEPTH)
        else $error("byte count beyond store depth");

    a_ack_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && op == OP_ACK && r_pend) |=> (!r_pend && r_count == '0))
        else $error("acknowledge did not clear message");

    a_wr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |=> (32'(r_count) == 32'($past(r_count)) + 1))
        else $error("store write without count advance");

    a_ovf_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.ovf) |=> (r_mode == MODE_IDLE && $stable(r_count)))
        else $error("overflow did not return to idle");
`endif

endmodule

@@ sv/afr_outbuf.sv @@
module afr_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  afr_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_valid,
    output logic             o_full,
    output afr_pkg::t_result o_result
);
    import afr_pkg::*;

    t_result r_out, r_skd;
    logic    r_out_vld, r_skd_vld;
    logic    out_fire;

    assign out_fire = r_out_vld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (r_skd_vld) begin
            if (out_fire) begin
                r_skd_vld <= 1'b0;
            end
        end else if (i_fire) begin
            if (!r_out_vld || out_fire) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skd_vld <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_vld) begin
            if (out_fire) begin
                r_out <= r_skd;
            end
        end else if (i_fire) begin
            if (!r_out_vld || out_fire) begin
                r_out <= i_result;
            end else begin
                r_skd <= i_result;
            end
        end
    end

    assign o_valid  = r_out_vld;
    assign o_full   = r_skd_vld;
    assign o_result = r_out;

endmodule

@@ sv/addressed_frame_receiver.sv @@
// Each accepted item goes to the result stage, then to the output buffer; the store
// is read at the accepting edge and the byte joins the result in the result stage.
// Throughput: one item per cycle while o_stall is low; frame state updates per item.
// A result stage and a two-entry output buffer keep accepting while one result
// waits; the input stalls only when all three hold results.
// Reset (synchronous, active low) clears mode, flags, count, address and buffer state.
module addressed_frame_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_rx_byte,
    input  logic [4:0] i_read_index,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_message_ready,
    output logic [5:0] o_message_length,
    output logic [7:0] o_read_data,
    output logic       o_overflow
);
    import afr_pkg::*;

    logic              fire;
    logic              s1_fire;
    logic              buf_full;
    logic              hit;
    t_wr               wr;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        q;
    t_result           res_new, res_s1, res_out;
    t_result           r_s1;
    logic              r_s1_hit;
    logic              r_s1_vld;

    assign o_stall = r_s1_vld && buf_full;
    assign fire    = i_valid && !o_stall;
    assign s1_fire = r_s1_vld && !buf_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (fire) begin
            r_s1_vld <= 1'b1;
        end else if (s1_fire) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1     <= res_new;
            r_s1_hit <= hit;
        end
    end

    always_comb begin
        res_s1    = r_s1;
        res_s1.rd = r_s1_hit ? q : 8'h00;
    end

    afr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_fire       (fire),
        .i_opcode     (i_opcode),
        .i_rx_byte    (i_rx_byte),
        .i_read_index (i_read_index),
        .o_wr         (wr),
        .o_rd_addr    (rd_addr),
        .o_hit        (hit),
        .o_result     (res_new)
    );

    afr_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (fire),
        .i_rd_addr (rd_addr),
        .o_q       (q)
    );

    afr_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s1_fire),
        .i_result (res_s1),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_full   (buf_full),
        .o_result (res_out)
    );

    assign o_message_ready  = res_out.ready;
    assign o_message_length = res_out.length;
    assign o_read_data      = res_out.rd;
    assign o_overflow       = res_out.ovf;

endmodule
